FILE: design/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-character mapping for the
// streaming base64 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] PadChar  = 8'h3d;
  localparam logic [7:0] MaskHi6  = 8'hfc;
  localparam logic [7:0] MaskLo2  = 8'h03;
  localparam logic [7:0] MaskHi4  = 8'hf0;
  localparam logic [7:0] MaskLo4  = 8'h0f;
  localparam logic [7:0] MaskHi2  = 8'hc0;
  localparam logic [7:0] MaskLo6  = 8'h3f;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_beat_t;

  // one encoded group: four sextets, index of last alphabet char, message end
  typedef struct packed {
    logic [3:0][5:0] sx;
    logic [1:0]      last_idx;
    logic            msg_last;
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t grp;
  } queue_head_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + ({2'b00, v} - 8'd26);
    end else if (v < 6'd62) begin
      c = 8'h30 + ({2'b00, v} - 8'd52);
    end else if (v == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Collects input bytes into groups of up to three and splits each finished
// group into sextets for the character queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               byte_valid,
  output logic              byte_stall,
  input  b64e_pkg::in_beat_t byte_beat,
  input  wire               q_full,
  output logic              push,
  output b64e_pkg::group_t  push_grp
);
  import b64e_pkg::*;

  logic [1:0][7:0] held_bytes;
  logic [1:0]      held_count;
  logic            accept;
  logic            flush;
  logic [1:0]      n;
  logic [7:0]      g0, g1, g2;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !byte_stall;
  assign n          = held_count + 2'd1;
  assign flush      = (held_count == 2'd2) || byte_beat.last_byte;
  assign push       = accept && flush;

  always_comb begin
    g0 = (held_count != 2'd0) ? held_bytes[0] : byte_beat.data_byte;
    g1 = (held_count == 2'd2) ? held_bytes[1] :
         ((held_count == 2'd1) ? byte_beat.data_byte : 8'd0);
    g2 = (held_count == 2'd2) ? byte_beat.data_byte : 8'd0;
    push_grp.sx[0]    = 6'((g0 & MaskHi6) >> 2);
    push_grp.sx[1]    = 6'(((g0 & MaskLo2) << 4) | ((g1 & MaskHi4) >> 4));
    push_grp.sx[2]    = 6'(((g1 & MaskLo4) << 2) | ((g2 & MaskHi2) >> 6));
    push_grp.sx[3]    = 6'(g2 & MaskLo6);
    push_grp.last_idx = n;
    push_grp.msg_last = byte_beat.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes <= '0;
      held_count <= 2'd0;
    end else if (accept) begin
      if (flush) begin
        held_bytes <= '0;
        held_count <= 2'd0;
      end else begin
        held_bytes[held_count[0]] <= byte_beat.data_byte;
        held_count                <= n;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd3)
    else $error("held count out of range");

  a_third_flushes: assert property (@(posedge clk) disable iff (rst)
    (accept && held_count == 2'd2) |-> push)
    else $error("full group not pushed");

  a_held_clear: assert property (@(posedge clk) disable iff (rst)
    push |=> (held_count == 2'd0))
    else $error("held state not cleared after flush");

endmodule

`default_nettype wire

FILE: design/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Small first-in first-out queue of encoded groups between the byte
// collector and the character serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::QueueDepthDefault
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  b64e_pkg::group_t      push_grp,
  output logic                  full,
  input  wire                   pop,
  output b64e_pkg::queue_head_t head
);
  import b64e_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  group_t        mem [DEPTH];
  logic [AW:0]   wr_ptr;
  logic [AW:0]   rd_ptr;
  logic          empty;

  assign empty     = (wr_ptr == rd_ptr);
  assign full      = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign head.valid = !empty;
  assign head.grp   = mem[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr[AW-1:0]] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("queue both full and empty");

endmodule

`default_nettype wire

FILE: design/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Walks the four characters of the group at the queue head, one per beat,
// into the registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
  input  wire                   clk,
  input  wire                   rst,
  input  b64e_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  char_valid,
  input  wire                   char_stall,
  output b64e_pkg::out_beat_t   char_beat
);
  import b64e_pkg::*;

  logic [1:0] k;
  logic       load;
  out_beat_t  beat_next;

  assign load = head.valid && (!char_valid || !char_stall);
  assign pop  = load && (k == 2'd3);

  always_comb begin
    beat_next.out_char = (k <= head.grp.last_idx) ? sextet_char(head.grp.sx[k]) : PadChar;
    beat_next.out_last = head.grp.msg_last && (k == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_beat <= beat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k          <= 2'd0;
      char_valid <= 1'b0;
    end else begin
      if (load) begin
        k          <= k + 2'd1;
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
    end
  end

  a_mid_group_head: assert property (@(posedge clk) disable iff (rst)
    (k != 2'd0) |-> head.valid)
    else $error("group index advanced without a queued group");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_stall) |=> (char_valid && $stable(char_beat)))
    else $error("output beat changed while stalled");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    (load && beat_next.out_last) |-> pop)
    else $error("last mark away from group end");

endmodule

`default_nettype wire

FILE: design/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet with '=' padding: bytes in,
// characters out, last character of each message marked.
// ----------------------------------------------------------------------------
//  channel  | handshake                    | beat
//  ---------+------------------------------+---------------------------------
//  byte in  | byte_valid / byte_stall      | byte_beat (data_byte, last_byte)
//  char out | char_valid / char_stall      | char_beat (out_char, out_last)
//
//  a byte is taken every cycle while the group queue has room; each group of
//  up to three bytes becomes four characters at one per cycle from the output
//  stage when not stalled, so sustained input is at best 3 bytes per 4
//  characters out, and one byte per 4 characters when every byte ends a
//  message (one byte per cycle for short bursts of up to QUEUE_DEPTH groups)
//  reset is synchronous and empties the held bytes, the queue and the output
//  output stalls back up into the queue; input stalls only when it is full
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::QueueDepthDefault
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  byte_valid,
  output logic                 byte_stall,
  input  b64e_pkg::in_beat_t   byte_beat,
  output logic                 char_valid,
  input  wire                  char_stall,
  output b64e_pkg::out_beat_t  char_beat
);
  import b64e_pkg::*;

  logic        q_full;
  logic        push;
  group_t      push_grp;
  logic        pop;
  queue_head_t head;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_beat  (byte_beat),
    .q_full     (q_full),
    .push       (push),
    .push_grp   (push_grp)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_grp (push_grp),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_beat  (char_beat)
  );

endmodule

`default_nettype wire
